/* rtl/fbi_pkg.sv */
// shared types and constants for the fasta block indexer
// no dependencies; imported by fbi_div, fasta_block_indexer and the testbench
package fbi_pkg;

  // position and count widths
  localparam int POS_W        = 48;
  localparam int DIV_CNT_W    = $clog2(POS_W);
  localparam int HDR_CNT_W    = 32;
  localparam int RES_CNT_W    = 11;
  localparam int BUDGET_W     = 10;
  localparam int LINE_SMP_W   = 4;
  localparam int CFG_IDX_W    = 2;

  typedef logic [POS_W-1:0] pos_t;

  // character codes
  localparam logic [7:0] HEADER_MARK = 8'h3E;
  localparam logic [7:0] NEWLINE     = 8'h0A;

  // sampling limits
  localparam logic [LINE_SMP_W-1:0] SAMPLE_BYTES_PER_LINE = 4'd10;
  localparam logic [RES_CNT_W-1:0]  RES_CNT_MAX   = '1;
  localparam logic [HDR_CNT_W-1:0]  HDR_CNT_MAX   = '1;
  localparam logic [BUDGET_W-1:0]   BUDGET_RESET  = 10'd100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BUDGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_ONLY     = 2'd2;

  // record and bank codes
  localparam logic       KIND_BLOCK   = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;
  localparam logic [1:0] BANK_UNKNOWN = 2'd0;
  localparam logic [1:0] BANK_NUC     = 2'd1;
  localparam logic [1:0] BANK_AMINO   = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_file;
  } text_t;

  typedef struct packed {
    logic                 record_kind;
    pos_t                 byte_offset;
    logic [HDR_CNT_W-1:0] sequence_count;
    pos_t                 residue_bytes;
    logic [1:0]           bank_kind;
    logic                 last_of_run;
  } rec_t;

endpackage

/* rtl/fbi_div.sv */
// restoring divider, one quotient bit per cycle, for block index lookup
// depends on fbi_pkg
module fbi_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  fbi_pkg::pos_t dividend,
  input  fbi_pkg::pos_t divisor,
  output logic         done,
  output fbi_pkg::pos_t quotient
);
  import fbi_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  pos_t                 rem;
  pos_t                 quo;
  logic [POS_W:0]       trial;
  logic [POS_W:0]       diff;
  logic                 fits;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[POS_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = !diff[POS_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? diff[POS_W-1:0] : trial[POS_W-1:0];
        quo <= {quo[POS_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* rtl/fasta_block_indexer.sv */
// channel   | direction | payload | handshake
// text      | in        | text_t  | text_valid / text_stall
// rec       | out       | rec_t   | rec_valid / rec_stall
// cfg       | in        | 48 bit  | cfg_wr_en, cfg_index, no wait
//
// a byte passes S_IDLE, S_START and S_BODY, plus S_ACCT when it ends a line or the file
// and S_SUM for a summary beat; after a type-only stop, S_IDLE and S_START plus any S_SUM;
// a header start with block_size nonzero adds S_DIV, waiting on the divider,
// plus S_BLK when a block record goes out
// rst is synchronous and clears the scan; registers return to 0, 100, 0
// text_stall is high while a byte is in work; a stalled rec beat holds
// the block waits in its emit states until the output register frees
// depends on fbi_pkg and fbi_div
module fasta_block_indexer (
  input  logic                           clk,
  input  logic                           rst,
  input  fbi_pkg::text_t                 text,
  input  logic                           text_valid,
  output logic                           text_stall,
  output fbi_pkg::rec_t                  rec,
  output logic                           rec_valid,
  input  logic                           rec_stall,
  input  logic                           cfg_wr_en,
  input  logic [fbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  fbi_pkg::pos_t                  cfg_data
);
  import fbi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DIV, S_BLK, S_BODY, S_ACCT, S_SUM
  } state_t;

  state_t state;

  // configuration registers
  pos_t                block_size;
  logic [BUDGET_W-1:0] sample_budget;
  logic                type_only;

  // latched beat
  logic [7:0] cur_byte;
  logic       cur_eof;

  // scan state
  pos_t                  byte_position;
  pos_t                  line_start_position;
  pos_t                  line_len;
  logic                  at_line_start;
  logic                  in_header_line;
  logic                  sampling_this_line;
  logic [LINE_SMP_W-1:0] bytes_in_line;
  logic [BUDGET_W-1:0]   budget_left;
  pos_t                  previous_block_index;
  logic                  block_index_valid;
  logic [HDR_CNT_W-1:0]  header_count;
  pos_t                  data_byte_count;
  logic [RES_CNT_W-1:0]  nucleotide_count;
  logic [RES_CNT_W-1:0]  other_residue_count;
  logic                  scan_stopped;
  logic                  scan_active;
  pos_t                  final_size;

  // divider hookup
  logic div_start;
  logic div_done;
  pos_t div_quotient;

  // combinational helpers
  logic                  is_nl;
  logic                  is_hdr;
  logic                  is_nuc;
  logic [7:0]            low_byte;
  logic [BUDGET_W-1:0]   budget_eff;
  pos_t                  len_base;
  logic [POS_W:0]        data_sum;
  logic                  out_free;
  logic                  rec_load;
  logic [1:0]            bank;
  logic [RES_CNT_W+1:0]  other_x4;

  fbi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (byte_position),
    .divisor  (block_size),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // byte classification and small arithmetic
  always_comb begin
    is_nl      = (cur_byte == NEWLINE);
    is_hdr     = (cur_byte == HEADER_MARK);
    low_byte   = cur_byte | 8'h20;
    is_nuc     = (low_byte == "a") || (low_byte == "c") || (low_byte == "g") ||
                 (low_byte == "t") || (low_byte == "n") || (low_byte == "u");
    budget_eff = scan_active ? budget_left : sample_budget;
    len_base   = at_line_start ? '0 : line_len;
    data_sum   = {1'b0, data_byte_count} + {1'b0, line_len};
    out_free   = !rec_valid || !rec_stall;
    rec_load   = out_free && ((state == S_BLK) || (state == S_SUM));
    other_x4   = {other_residue_count, 2'b00};
    if ((nucleotide_count == '0) && (other_residue_count == '0)) begin
      bank = BANK_UNKNOWN;
    end else if ({2'b00, nucleotide_count} >= other_x4) begin
      bank = BANK_NUC;
    end else begin
      bank = BANK_AMINO;
    end
  end

  // a header start, while the scan runs and block_size is nonzero, kicks the divider
  assign div_start = (state == S_START) && !scan_stopped && at_line_start && is_hdr &&
                     (block_size != '0);

  assign text_stall = (state != S_IDLE);

  // sequencer, scan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      block_size           <= '0;
      sample_budget        <= BUDGET_RESET;
      type_only            <= 1'b0;
      rec_valid            <= 1'b0;
      byte_position        <= '0;
      line_start_position  <= '0;
      line_len             <= '0;
      at_line_start        <= 1'b1;
      in_header_line       <= 1'b0;
      sampling_this_line   <= 1'b0;
      bytes_in_line        <= '0;
      budget_left          <= '0;
      previous_block_index <= '0;
      block_index_valid    <= 1'b0;
      header_count         <= '0;
      data_byte_count      <= '0;
      nucleotide_count     <= '0;
      other_residue_count  <= '0;
      scan_stopped         <= 1'b0;
      scan_active          <= 1'b0;
      final_size           <= '0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BLOCK_SIZE:    block_size    <= cfg_data;
          REG_SAMPLE_BUDGET: sample_budget <= cfg_data[BUDGET_W-1:0];
          REG_TYPE_ONLY:     type_only     <= cfg_data[0];
          default:           ;
        endcase
      end

      // output beat leaves
      if (rec_valid && !rec_stall && !rec_load) begin
        rec_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (text_valid) begin
            cur_byte <= text.text_byte;
            cur_eof  <= text.end_of_file;
            state    <= S_START;
          end
        end

        S_START: begin
          if (scan_stopped) begin
            state <= cur_eof ? S_SUM : S_IDLE;
          end else begin
            scan_active   <= 1'b1;
            budget_left   <= budget_eff;
            line_len      <= len_base + (is_nl ? '0 : POS_W'(1));
            byte_position <= byte_position + 1'b1;
            state         <= div_start ? S_DIV : S_BODY;
            if (at_line_start) begin
              line_start_position <= byte_position;
              at_line_start       <= 1'b0;
              bytes_in_line       <= '0;
              if (is_hdr) begin
                in_header_line     <= 1'b1;
                sampling_this_line <= 1'b0;
                if (header_count != HDR_CNT_MAX) begin
                  header_count <= header_count + 1'b1;
                end
              end else begin
                in_header_line     <= 1'b0;
                sampling_this_line <= (budget_eff != '0);
              end
            end
          end
        end

        // wait for the block index
        S_DIV: begin
          if (div_done) begin
            if (!block_index_valid || (div_quotient != previous_block_index)) begin
              previous_block_index <= div_quotient;
              block_index_valid    <= 1'b1;
              state                <= S_BLK;
            end else begin
              state <= S_BODY;
            end
          end
        end

        // block offset record at the header start
        S_BLK: begin
          if (out_free) begin
            rec_valid          <= 1'b1;
            rec.record_kind    <= KIND_BLOCK;
            rec.byte_offset    <= line_start_position;
            rec.sequence_count <= header_count;
            rec.residue_bytes  <= data_byte_count;
            rec.bank_kind      <= BANK_UNKNOWN;
            rec.last_of_run    <= !cur_eof;
            state              <= S_BODY;
          end
        end

        // sample the byte
        S_BODY: begin
          if (!in_header_line && sampling_this_line && !is_nl &&
              (bytes_in_line < SAMPLE_BYTES_PER_LINE)) begin
            if (is_nuc) begin
              if (nucleotide_count != RES_CNT_MAX) begin
                nucleotide_count <= nucleotide_count + 1'b1;
              end
            end else begin
              if (other_residue_count != RES_CNT_MAX) begin
                other_residue_count <= other_residue_count + 1'b1;
              end
            end
            bytes_in_line <= bytes_in_line + 1'b1;
          end
          if (is_nl || cur_eof) begin
            state <= S_ACCT;
          end else begin
            final_size <= byte_position;
            state      <= S_IDLE;
          end
        end

        // line end accounting
        S_ACCT: begin
          at_line_start <= 1'b1;
          if (!in_header_line && sampling_this_line && type_only) begin
            scan_stopped <= 1'b1;
            final_size   <= line_start_position;
          end else begin
            final_size <= byte_position;
            if (!in_header_line) begin
              if (sampling_this_line) begin
                budget_left <= (budget_left > BUDGET_W'(bytes_in_line)) ?
                               budget_left - BUDGET_W'(bytes_in_line) : '0;
              end
              data_byte_count <= data_sum[POS_W] ? '1 : data_sum[POS_W-1:0];
            end
          end
          state <= cur_eof ? S_SUM : S_IDLE;
        end

        // summary record, then back to a fresh scan
        S_SUM: begin
          if (out_free) begin
            rec_valid            <= 1'b1;
            rec.record_kind      <= KIND_SUMMARY;
            rec.byte_offset      <= final_size;
            rec.sequence_count   <= header_count;
            rec.residue_bytes    <= data_byte_count;
            rec.bank_kind        <= bank;
            rec.last_of_run      <= 1'b1;
            byte_position        <= '0;
            line_start_position  <= '0;
            line_len             <= '0;
            at_line_start        <= 1'b1;
            in_header_line       <= 1'b0;
            sampling_this_line   <= 1'b0;
            bytes_in_line        <= '0;
            budget_left          <= '0;
            previous_block_index <= '0;
            block_index_valid    <= 1'b0;
            header_count         <= '0;
            data_byte_count      <= '0;
            nucleotide_count     <= '0;
            other_residue_count  <= '0;
            scan_stopped         <= 1'b0;
            scan_active          <= 1'b0;
            final_size           <= '0;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/fasta_block_indexer_test.sv */
// self-checking testbench for fasta_block_indexer: streams FASTA files and checks records
// carries its own scan predictor; depends on fbi_pkg and the fasta_block_indexer rtl
`timescale 1ns / 1ps

module fasta_block_indexer_test;
  import fbi_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_GAP      = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // sampled bytes per data line, as the block counts them
  localparam int LINE_CAP = SAMPLE_BYTES_PER_LINE;

  logic clk = 1'b0;
  logic rst = 1'b1;
  text_t text = '0;
  logic text_valid = 1'b0;
  logic text_stall;
  rec_t rec;
  logic rec_valid;
  logic rec_stall = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  pos_t cfg_data = '0;

  int sender_idle_pct = 0;
  int rec_stall_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;

  // register copies
  pos_t blk_size_reg = '0;
  logic [BUDGET_W-1:0] budget_reg = BUDGET_RESET;
  logic type_only_reg = 1'b0;

  // predicted scan state
  pos_t cur_pos, line_pos, last_blk, residues, final_pos;
  logic [HDR_CNT_W-1:0] hdr_cnt;
  logic [LINE_SMP_W-1:0] line_smp;
  logic [BUDGET_W-1:0] budget_left;
  logic [RES_CNT_W-1:0] nuc_cnt, oth_cnt;
  logic at_start, in_hdr, smp_line, blk_seen, scan_halted, scan_open;

  rec_t pending_records[$];

  fasta_block_indexer dut (
    .clk(clk),
    .rst(rst),
    .text(text),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .rec(rec),
    .rec_valid(rec_valid),
    .rec_stall(rec_stall),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // random receiver back-pressure
  always @(posedge clk) begin
    rec_stall <= (rec_stall_pct != 0) && ($urandom_range(99) < rec_stall_pct);
  end

  function automatic void clear_scan();
    cur_pos = '0; line_pos = '0; last_blk = '0; residues = '0; final_pos = '0;
    hdr_cnt = '0; line_smp = '0; budget_left = '0; nuc_cnt = '0; oth_cnt = '0;
    at_start = 1'b1; in_hdr = 1'b0; smp_line = 1'b0;
    blk_seen = 1'b0; scan_halted = 1'b0; scan_open = 1'b0;
  endfunction

  function automatic rec_t make_rec(logic kind, pos_t off, logic [1:0] bank);
    rec_t r;
    r.record_kind = kind;
    r.byte_offset = off;
    r.sequence_count = hdr_cnt;
    r.residue_bytes = residues;
    r.bank_kind = bank;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // advance the predicted scan by one byte and queue the records it yields
  task automatic index_byte(input logic [7:0] b, input logic eof);
    rec_t outs[$];
    pos_t here, blk, len;
    logic nl, nuc;
    logic [7:0] lc;
    logic [POS_W:0] sum;
    logic [1:0] bank;
    if (!scan_open) begin
      scan_open = 1'b1;
      budget_left = budget_reg;
    end
    if (!scan_halted) begin
      here = cur_pos;
      nl = (b == NEWLINE);
      // line start: header or data line decision
      if (at_start) begin
        line_pos = here;
        at_start = 1'b0;
        line_smp = '0;
        if (b == HEADER_MARK) begin
          in_hdr = 1'b1;
          smp_line = 1'b0;
          if (hdr_cnt != HDR_CNT_MAX) hdr_cnt++;
          if (blk_size_reg != '0) begin
            blk = here / blk_size_reg;
            if (!blk_seen || blk != last_blk) begin
              outs.insert(outs.size(), make_rec(KIND_BLOCK, here, BANK_UNKNOWN));
              last_blk = blk;
              blk_seen = 1'b1;
            end
          end
        end else begin
          in_hdr = 1'b0;
          smp_line = (budget_left != '0);
        end
      end
      // residue sampling
      if (!in_hdr && smp_line && !nl && line_smp < LINE_CAP) begin
        lc = b | 8'h20;
        nuc = (lc == "a") || (lc == "c") || (lc == "g") || (lc == "t") ||
              (lc == "n") || (lc == "u");
        if (nuc) begin
          if (nuc_cnt != RES_CNT_MAX) nuc_cnt++;
        end else begin
          if (oth_cnt != RES_CNT_MAX) oth_cnt++;
        end
        line_smp++;
      end
      // line end accounting
      if (nl || eof) begin
        len = (nl ? here : here + 1) - line_pos;
        if (!in_hdr) begin
          if (smp_line && type_only_reg) begin
            scan_halted = 1'b1;
            final_pos = line_pos;
          end else begin
            if (smp_line)
              budget_left = (budget_left > BUDGET_W'(line_smp)) ?
                            budget_left - BUDGET_W'(line_smp) : '0;
            sum = {1'b0, residues} + {1'b0, len};
            residues = sum[POS_W] ? '1 : sum[POS_W-1:0];
          end
        end
        at_start = 1'b1;
      end
      if (!scan_halted) final_pos = here + 1;
      cur_pos = here + 1;
    end
    // summary on the last byte
    if (eof) begin
      if (nuc_cnt == '0 && oth_cnt == '0) bank = BANK_UNKNOWN;
      else if ({2'b00, nuc_cnt} >= {oth_cnt, 2'b00}) bank = BANK_NUC;
      else bank = BANK_AMINO;
      outs.insert(outs.size(), make_rec(KIND_SUMMARY, final_pos, bank));
      clear_scan();
    end
    if (outs.size() > 0) outs[outs.size()-1].last_of_run = 1'b1;
    foreach (outs[i]) pending_records.insert(pending_records.size(), outs[i]);
  endtask

  // send one byte beat; valid stays high after acceptance for the next call
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = 0;
    while (sender_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
      gap++;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text <= '{text_byte: b, end_of_file: eof};
    text_valid <= 1'b1;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    index_byte(b, eof);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eof_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eof_last && (i == s.len() - 1));
  endtask

  // stop input and let every expected record arrive
  task automatic settle();
    text_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all registers while idle, plus one write to an unused index
  task automatic set_config(input pos_t bsize, input logic [BUDGET_W-1:0] budget,
                            input logic tonly);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= pos_t'({$urandom, $urandom});
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data <= bsize;
    @(posedge clk);
    cfg_index <= REG_SAMPLE_BUDGET;
    cfg_data <= pos_t'(budget);
    @(posedge clk);
    cfg_index <= REG_TYPE_ONLY;
    cfg_data <= pos_t'(tonly);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    blk_size_reg = bsize;
    budget_reg = budget;
    type_only_reg = tonly;
  endtask

  function automatic logic [7:0] pick_char(input int mode);
    string nucs;
    string aminos;
    nucs = "ACGTNUacgtnu";
    aminos = "ACDEFGHIKLMNPQRSTVWYacdefhiklmpqrsvwy*-";
    case (mode)
      0: begin
        if ($urandom_range(9) == 0) return aminos[$urandom_range(aminos.len() - 1)];
        return nucs[$urandom_range(nucs.len() - 1)];
      end
      1: return aminos[$urandom_range(aminos.len() - 1)];
      2: return 8'($urandom_range(33, 126));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // header start that is also end of file, extreme byte, two blocks
  task automatic test_record_pairs();
    set_config(48'd1, BUDGET_RESET, 1'b0);
    send_byte(HEADER_MARK, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text(">\n>", 1'b1);
  endtask

  // four nucleotides against one other sits exactly on the nucleotide side
  task automatic test_kind_ratio();
    set_config('1, 10'd1000, 1'b0);
    send_text("ACGTx", 1'b1);
  endtask

  // type-only stop after the first sampled line, later bytes ignored
  task automatic test_type_only();
    set_config('1, 10'd1000, 1'b1);
    send_text("Ac\nZ>", 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // per-line sample cap and budget running out
  task automatic test_line_cap();
    set_config('0, 10'd1, 1'b0);
    send_text("ACGTNUacgtn\n*", 1'b1);
  endtask

  // random files, mostly well formed, some noise
  task automatic test_random_files(input int idle, input int stall, input int count);
    logic [7:0] file_bytes[$];
    int stop_at, lines, len, mode;
    pos_t bsize;
    logic [BUDGET_W-1:0] budget;
    set_config(blk_size_reg, budget_reg, type_only_reg);
    sender_idle_pct = idle;
    rec_stall_pct = stall;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      // new register setting now and then
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: bsize = '0;
          1: bsize = 48'd1;
          2: bsize = pos_t'($urandom_range(2, 40));
          default: bsize = '1;
        endcase
        case ($urandom_range(3))
          0: budget = '0;
          1: budget = 10'd1;
          2: budget = 10'($urandom_range(2, 80));
          default: budget = 10'd1000;
        endcase
        set_config(bsize, budget, $urandom_range(3) == 0);
      end
      file_bytes.delete();
      if ($urandom_range(4) == 0) begin
        len = $urandom_range(1, 30);
        repeat (len)
          file_bytes.insert(file_bytes.size(),
                            ($urandom_range(5) == 0) ? NEWLINE : pick_char(3));
      end else begin
        lines = $urandom_range(1, 6);
        mode = $urandom_range(2);
        repeat (lines) begin
          if ($urandom_range(2) == 0) begin
            file_bytes.insert(file_bytes.size(), HEADER_MARK);
            repeat ($urandom_range(0, 4)) file_bytes.insert(file_bytes.size(), pick_char(2));
          end else begin
            len = $urandom_range(0, 14);
            repeat (len) file_bytes.insert(file_bytes.size(), pick_char(mode));
          end
          file_bytes.insert(file_bytes.size(), NEWLINE);
        end
        // file may end without a trailing newline
        if ($urandom_range(1) == 0) void'(file_bytes.pop_back());
        if (file_bytes.size() == 0) file_bytes.insert(0, pick_char(mode));
      end
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  // result checking against the oldest expected record
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    rec_t want;
    if (!rst && rec_valid && !rec_stall) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record beat, expected none, actual %h", $time, rec);
        mismatch_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", 64'(want.record_kind), 64'(rec.record_kind));
        check_field("byte_offset", 64'(want.byte_offset), 64'(rec.byte_offset));
        check_field("sequence_count", 64'(want.sequence_count),
                    64'(rec.sequence_count));
        check_field("residue_bytes", 64'(want.residue_bytes), 64'(rec.residue_bytes));
        check_field("bank_kind", 64'(want.bank_kind), 64'(rec.bank_kind));
        check_field("last_of_run", 64'(want.last_of_run), 64'(rec.last_of_run));
      end
    end
  end

  initial begin
    clear_scan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_record_pairs();
    test_kind_ratio();
    test_type_only();
    test_line_cap();
    test_random_files(0, 0, 100);
    test_random_files(58, 0, 100);
    test_random_files(0, 58, 100);
    test_random_files(15, 15, 100);
    settle();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
rtl/fbi_pkg.sv
rtl/fbi_div.sv
rtl/fasta_block_indexer.sv
sim/fasta_block_indexer_test.sv
